// File: hw/rtl/gcbs_pkg.sv
// ----------------------------------------------------------------------------
// gcbs_pkg
// Shared types, codes and helpers of the greedy class box suppression unit.
// ----------------------------------------------------------------------------
package gcbs_pkg;

   // result codes of one transaction
   typedef enum logic [2:0] {
      OUT_BELOW      = 3'd0,
      OUT_SUPPRESSED = 3'd1,
      OUT_APPENDED   = 3'd2,
      OUT_REPLACED   = 3'd3,
      OUT_FULL       = 3'd4
   } outcome_type;

   // one kept-table entry, as stored in the table RAM
   typedef struct packed {
      logic [15:0] left;
      logic [15:0] top;
      logic [15:0] right;
      logic [15:0] bottom;
      logic [15:0] score;
      logic [7:0]  class_id;
      logic [31:0] area;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // overlap pipeline status toward the controller
   typedef struct packed {
      logic        hit;
      logic        busy;
      logic [15:0] score;
   } ovl_status_type;

   // length of [lo, hi), zero when empty
   function automatic logic [15:0] span(input logic [15:0] lo, input logic [15:0] hi);
      return (hi > lo) ? 16'(hi - lo) : 16'd0;
   endfunction

   function automatic logic [15:0] umax16(input logic [15:0] a, input logic [15:0] b);
      return (a > b) ? a : b;
   endfunction

   function automatic logic [15:0] umin16(input logic [15:0] a, input logic [15:0] b);
      return (a < b) ? a : b;
   endfunction

endpackage

// File: hw/rtl/gcbs_ram.sv
// ----------------------------------------------------------------------------
// gcbs_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gcbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/gcbs_overlap.sv
// ----------------------------------------------------------------------------
// gcbs_overlap
// Two-stage overlap test of the candidate against one kept entry per cycle:
// class match and intersection extents, then 3*intersection > area sum.
// ----------------------------------------------------------------------------
module gcbs_overlap #(
   parameter int IDX_W = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       flush,
   input  logic                       in_valid,
   input  logic [IDX_W-1:0]           in_idx,
   input  gcbs_pkg::entry_type        kept,
   input  gcbs_pkg::entry_type        cand,
   output gcbs_pkg::ovl_status_type   status,
   output logic [IDX_W-1:0]           hit_idx
);

   logic              a_valid_ff, a_valid_in;
   logic              a_match_ff, a_match_in;
   logic [IDX_W-1:0]  a_idx_ff;
   logic [15:0]       a_w_ff, a_w_in;
   logic [15:0]       a_h_ff, a_h_in;
   logic [32:0]       a_sum_ff;
   logic [15:0]       a_score_ff;

   logic              b_valid_ff, b_valid_in;
   logic [IDX_W-1:0]  b_idx_ff;
   logic [31:0]       b_inter_ff;
   logic [32:0]       b_sum_ff;
   logic [15:0]       b_score_ff;

   logic [33:0]       triple;

   // stage A: class match and intersection width/height
   always_comb begin
      a_w_in = gcbs_pkg::span(gcbs_pkg::umax16(cand.left, kept.left),
                              gcbs_pkg::umin16(cand.right, kept.right));
      a_h_in = gcbs_pkg::span(gcbs_pkg::umax16(cand.top, kept.top),
                              gcbs_pkg::umin16(cand.bottom, kept.bottom));
      a_match_in = (cand.class_id == kept.class_id) && (a_w_in != 16'd0) &&
                   (a_h_in != 16'd0);
      a_valid_in = in_valid && !flush;
      b_valid_in = a_valid_ff && a_match_ff && !flush;
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      a_match_ff <= a_match_in;
      a_idx_ff   <= in_idx;
      a_w_ff     <= a_w_in;
      a_h_ff     <= a_h_in;
      a_sum_ff   <= 33'(cand.area) + 33'(kept.area);
      a_score_ff <= kept.score;
      b_idx_ff   <= a_idx_ff;
      b_inter_ff <= {16'd0, a_w_ff} * {16'd0, a_h_ff};
      b_sum_ff   <= a_sum_ff;
      b_score_ff <= a_score_ff;
   end

   // stage B: IoU above one half
   assign triple       = {1'b0, b_inter_ff, 1'b0} + {2'b00, b_inter_ff};
   assign status.hit   = b_valid_ff && (triple > {1'b0, b_sum_ff});
   assign status.busy  = a_valid_ff || b_valid_ff;
   assign status.score = b_score_ff;
   assign hit_idx      = b_idx_ff;

   property p_flush_clears;
      @(posedge clock) disable iff (reset) flush |=> !status.busy;
   endproperty
   a_flush_clears: assert property (p_flush_clears)
      else $error("overlap pipeline busy after flush");

endmodule

// File: hw/rtl/greedy_class_box_suppression_unit.sv
// ----------------------------------------------------------------------------
// greedy_class_box_suppression_unit
// Greedy per-class box suppression over a kept table held in one RAM.
//
//   channel  dir   handshake               payload
//   req      in    req_valid/req_ready     new_frame, box corners, score,
//                                          class_id, anchor_index
//   rsp      out   rsp_valid/rsp_ready     outcome, slot, anchor_echo,
//                                          kept_total
//   csr      in    csr_valid/csr_ready     score_threshold
//
// One transaction at a time. Below threshold the area state goes straight to
// the result, with no scan. Otherwise the table RAM read port walks the kept
// entries one per cycle (none on an empty table), then the RAM read register
// and two overlap stages drain; a hit on an entry ends the walk. The next
// transaction can be taken in the cycle after the result loads. Reset is
// synchronous; the table needs no clearing pass. A stalled result holds; the
// next transaction is taken meanwhile and waits for the output register.
// ----------------------------------------------------------------------------
module greedy_class_box_suppression_unit #(
   parameter int MAX_KEPT = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_new_frame,
   input  logic [15:0] req_box_left,
   input  logic [15:0] req_box_top,
   input  logic [15:0] req_box_right,
   input  logic [15:0] req_box_bottom,
   input  logic [15:0] req_box_score,
   input  logic [7:0]  req_class_id,
   input  logic [15:0] req_anchor_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_outcome,
   output logic [7:0]  rsp_slot,
   output logic [15:0] rsp_anchor_echo,
   output logic [8:0]  rsp_kept_total,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_score_threshold
);

   localparam int IDX_W = $clog2(MAX_KEPT);
   localparam int CNT_W = $clog2(MAX_KEPT + 1);
   localparam logic [CNT_W-1:0] MaxCount = CNT_W'(MAX_KEPT);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_AREA   = 4'b0010,
      ST_SCAN   = 4'b0100,
      ST_RESULT = 4'b1000
   } state_type;

   state_type                 state_ff, state_in;
   logic [15:0]               thr_ff, thr_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   gcbs_pkg::entry_type       cand_ff, cand_in;
   logic [15:0]               anchor_ff, anchor_in;
   logic [CNT_W-1:0]          rd_idx_ff, rd_idx_in;
   logic                      issuing_ff, issuing_in;
   logic                      v1_ff, v1_in;
   logic [IDX_W-1:0]          idx1_ff;
   gcbs_pkg::outcome_type     dec_outcome_ff, dec_outcome_in;
   logic [IDX_W-1:0]          dec_slot_ff, dec_slot_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   gcbs_pkg::outcome_type     rsp_outcome_ff, rsp_outcome_in;
   logic [7:0]                rsp_slot_ff, rsp_slot_in;
   logic [15:0]               rsp_anchor_ff, rsp_anchor_in;
   logic [8:0]                rsp_total_ff, rsp_total_in;

   logic                      req_accept;
   logic                      rsp_free;
   logic                      rsp_load;
   logic                      ram_rd_en;
   logic                      ram_we;
   logic                      pipe_empty;
   gcbs_pkg::entry_type       ram_rd_data;
   gcbs_pkg::ovl_status_type  ovl;
   logic [IDX_W-1:0]          ovl_idx;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign rsp_load   = (state_ff == ST_RESULT) && rsp_free;
   assign ram_rd_en  = (state_ff == ST_SCAN) && issuing_ff;
   assign ram_we     = rsp_load && ((dec_outcome_ff == gcbs_pkg::OUT_APPENDED) ||
                                    (dec_outcome_ff == gcbs_pkg::OUT_REPLACED));
   assign pipe_empty = !issuing_ff && !v1_ff && !ovl.busy;

   // kept table
   gcbs_ram #(
      .WIDTH (gcbs_pkg::ENTRY_W),
      .DEPTH (MAX_KEPT)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (dec_slot_ff),
      .wr_data (cand_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_idx_ff[IDX_W-1:0]),
      .rd_data (ram_rd_data)
   );

   // overlap test pipeline
   gcbs_overlap #(
      .IDX_W (IDX_W)
   ) u_overlap (
      .clock    (clock),
      .reset    (reset),
      .flush    (ovl.hit),
      .in_valid (v1_ff),
      .in_idx   (idx1_ff),
      .kept     (ram_rd_data),
      .cand     (cand_ff),
      .status   (ovl),
      .hit_idx  (ovl_idx)
   );

   // sequencer
   always_comb begin
      state_in       = state_ff;
      thr_in         = thr_ff;
      count_in       = count_ff;
      cand_in        = cand_ff;
      anchor_in      = anchor_ff;
      rd_idx_in      = rd_idx_ff;
      issuing_in     = issuing_ff;
      v1_in          = ram_rd_en && !ovl.hit;
      dec_outcome_in = dec_outcome_ff;
      dec_slot_in    = dec_slot_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_outcome_in = rsp_outcome_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_anchor_in  = rsp_anchor_ff;
      rsp_total_in   = rsp_total_ff;

      if (csr_valid && csr_ready) begin
         thr_in = csr_score_threshold;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cand_in.left     = req_box_left;
               cand_in.top      = req_box_top;
               cand_in.right    = req_box_right;
               cand_in.bottom   = req_box_bottom;
               cand_in.score    = req_box_score;
               cand_in.class_id = req_class_id;
               cand_in.area     = 32'd0;
               anchor_in        = req_anchor_index;
               if (req_new_frame) begin
                  count_in = '0;
               end
               state_in = ST_AREA;
            end
         end
         ST_AREA: begin
            cand_in.area = {16'd0, gcbs_pkg::span(cand_ff.left, cand_ff.right)} *
                           {16'd0, gcbs_pkg::span(cand_ff.top, cand_ff.bottom)};
            rd_idx_in    = '0;
            if (cand_ff.score < thr_ff) begin
               dec_outcome_in = gcbs_pkg::OUT_BELOW;
               dec_slot_in    = '0;
               state_in       = ST_RESULT;
            end else begin
               issuing_in = (count_ff != '0);
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (ram_rd_en) begin
               rd_idx_in = CNT_W'(rd_idx_ff + 1'b1);
               if (CNT_W'(rd_idx_ff + 1'b1) == count_ff) begin
                  issuing_in = 1'b0;
               end
            end
            if (ovl.hit) begin
               // first overlapping entry of the same class decides
               issuing_in = 1'b0;
               if (cand_ff.score > ovl.score) begin
                  dec_outcome_in = gcbs_pkg::OUT_REPLACED;
                  dec_slot_in    = ovl_idx;
               end else begin
                  dec_outcome_in = gcbs_pkg::OUT_SUPPRESSED;
                  dec_slot_in    = '0;
               end
               state_in = ST_RESULT;
            end else if (pipe_empty) begin
               if (count_ff < MaxCount) begin
                  dec_outcome_in = gcbs_pkg::OUT_APPENDED;
                  dec_slot_in    = count_ff[IDX_W-1:0];
               end else begin
                  dec_outcome_in = gcbs_pkg::OUT_FULL;
                  dec_slot_in    = '0;
               end
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (rsp_free) begin
               if (dec_outcome_ff == gcbs_pkg::OUT_APPENDED) begin
                  count_in = CNT_W'(count_ff + 1'b1);
               end
               rsp_valid_in   = 1'b1;
               rsp_outcome_in = dec_outcome_ff;
               rsp_slot_in    = 8'(dec_slot_ff);
               rsp_anchor_in  = anchor_ff;
               rsp_total_in   = 9'(count_in);
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         thr_ff       <= 16'd45875;
         count_ff     <= '0;
         issuing_ff   <= 1'b0;
         v1_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         thr_ff       <= thr_in;
         count_ff     <= count_in;
         issuing_ff   <= issuing_in;
         v1_ff        <= v1_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cand_ff        <= cand_in;
      anchor_ff      <= anchor_in;
      rd_idx_ff      <= rd_idx_in;
      idx1_ff        <= rd_idx_ff[IDX_W-1:0];
      dec_outcome_ff <= dec_outcome_in;
      dec_slot_ff    <= dec_slot_in;
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_anchor_ff  <= rsp_anchor_in;
      rsp_total_ff   <= rsp_total_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_outcome     = rsp_outcome_ff;
   assign rsp_slot        = rsp_slot_ff;
   assign rsp_anchor_echo = rsp_anchor_ff;
   assign rsp_kept_total  = rsp_total_ff;

   property p_write_in_result;
      @(posedge clock) disable iff (reset) ram_we |-> (state_ff == ST_RESULT);
   endproperty
   a_write_in_result: assert property (p_write_in_result)
      else $error("table written outside result state");

   property p_count_bound;
      @(posedge clock) disable iff (reset) count_ff <= MaxCount;
   endproperty
   a_count_bound: assert property (p_count_bound)
      else $error("kept count above table depth");

   property p_hit_in_scan;
      @(posedge clock) disable iff (reset) ovl.hit |-> (state_ff == ST_SCAN);
   endproperty
   a_hit_in_scan: assert property (p_hit_in_scan)
      else $error("overlap hit outside scan");

   property p_append_counts;
      @(posedge clock) disable iff (reset)
         (rsp_load && (dec_outcome_ff == gcbs_pkg::OUT_APPENDED)) |=>
            (count_ff == CNT_W'($past(count_ff) + 1'b1));
   endproperty
   a_append_counts: assert property (p_append_counts)
      else $error("append did not advance kept count");

endmodule

// File: test/greedy_class_box_suppression_unit_test.sv
// ----------------------------------------------------------------------------
// greedy_class_box_suppression_unit_test
// Self-checking bench for the greedy class box suppression unit. Candidates
// go in over the req channel and a kept-table model predicts each verdict.
// Verdicts on the rsp channel are checked in order against that prediction.
// The run starts with directed corner cases and then moves through threshold
// phases: short random frames with clustered boxes, noise and degenerate
// boxes, and frames that fill the table. Both sides stall at random except
// in the last phase.
// ----------------------------------------------------------------------------
module greedy_class_box_suppression_unit_test;

   localparam int          TABLE_DEPTH     = 256;
   localparam int          CYCLE_LIMIT     = 4_000_000;
   localparam int          RANDOM_ITEMS    = 2000;
   localparam int          PHASES          = 7;
   localparam int          GRID_PITCH      = 4000;
   localparam logic [15:0] RESET_THRESHOLD = 16'd45875;

   // one candidate transaction on the req channel
   typedef struct {
      logic        new_frame;
      logic [15:0] left;
      logic [15:0] top;
      logic [15:0] right;
      logic [15:0] bottom;
      logic [15:0] score;
      logic [7:0]  class_id;
      logic [15:0] anchor;
   } candidate_type;

   // one verdict transaction on the rsp channel
   typedef struct {
      gcbs_pkg::outcome_type outcome;
      logic [7:0]            slot;
      logic [15:0]           anchor_echo;
      logic [8:0]            kept_total;
   } verdict_type;

   // Kept-table model: predicts the verdict of every accepted candidate and
   // checks returned verdicts against them in order.
   class suppression_tracker;
      logic [15:0]         threshold;
      int                  kept_count;
      gcbs_pkg::entry_type kept [TABLE_DEPTH];
      verdict_type         pending_verdicts [$];
      int                  errors;

      function new();
         threshold  = RESET_THRESHOLD;
         kept_count = 0;
         errors     = 0;
      endfunction

      function logic [31:0] extent(logic [15:0] lo, logic [15:0] hi);
         return (hi > lo) ? {16'd0, hi - lo} : 32'd0;
      endfunction

      function void note_candidate(candidate_type c);
         verdict_type         v;
         gcbs_pkg::entry_type fresh;
         logic [31:0]         area;
         logic [31:0]         w;
         logic [31:0]         h;
         logic [63:0]         inter;
         logic [15:0]         lo;
         logic [15:0]         hi;
         bit                  decided;

         v.outcome     = gcbs_pkg::OUT_BELOW;
         v.slot        = 8'd0;
         v.anchor_echo = c.anchor;
         decided       = 1'b0;
         if (c.new_frame)
            kept_count = 0;
         area  = extent(c.left, c.right) * extent(c.top, c.bottom);
         fresh = '{left: c.left, top: c.top, right: c.right, bottom: c.bottom,
                   score: c.score, class_id: c.class_id, area: area};

         if (c.score >= threshold) begin
            // first same-class entry with IoU above one half decides
            for (int i = 0; i < kept_count && !decided; i++) begin
               if (kept[i].class_id != c.class_id)
                  continue;
               lo = (c.left > kept[i].left) ? c.left : kept[i].left;
               hi = (c.right < kept[i].right) ? c.right : kept[i].right;
               w  = extent(lo, hi);
               if (w == 0)
                  continue;
               lo = (c.top > kept[i].top) ? c.top : kept[i].top;
               hi = (c.bottom < kept[i].bottom) ? c.bottom : kept[i].bottom;
               h  = extent(lo, hi);
               if (h == 0)
                  continue;
               inter = 64'(w) * 64'(h);
               if (3 * inter <= 64'(area) + 64'(kept[i].area))
                  continue;
               decided = 1'b1;
               if (c.score > kept[i].score) begin
                  kept[i]   = fresh;
                  v.outcome = gcbs_pkg::OUT_REPLACED;
                  v.slot    = 8'(i);
               end else begin
                  v.outcome = gcbs_pkg::OUT_SUPPRESSED;
               end
            end
            if (!decided) begin
               if (kept_count < TABLE_DEPTH) begin
                  kept[kept_count] = fresh;
                  v.slot           = 8'(kept_count);
                  kept_count++;
                  v.outcome        = gcbs_pkg::OUT_APPENDED;
               end else begin
                  v.outcome = gcbs_pkg::OUT_FULL;
               end
            end
         end
         v.kept_total = 9'(kept_count);
         pending_verdicts.push_back(v);
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         errors++;
         $display("%0t: %s is %0d, expected %0d", $time, what, got, want);
      endtask

      task check_verdict(verdict_type got);
         verdict_type want;
         string       tag;

         if (pending_verdicts.size() == 0) begin
            report("unexpected verdict, anchor_echo", got.anchor_echo, 0);
            return;
         end
         want = pending_verdicts.pop_front();
         tag  = $sformatf("anchor %0d", want.anchor_echo);
         if (got.outcome !== want.outcome)
            report({tag, " outcome"}, got.outcome, want.outcome);
         if (got.slot !== want.slot)
            report({tag, " slot"}, got.slot, want.slot);
         if (got.anchor_echo !== want.anchor_echo)
            report({tag, " anchor_echo"}, got.anchor_echo, want.anchor_echo);
         if (got.kept_total !== want.kept_total)
            report({tag, " kept_total"}, got.kept_total, want.kept_total);
      endtask
   endclass

   // DUT signals
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_new_frame = 1'b0;
   logic [15:0] req_box_left = '0;
   logic [15:0] req_box_top = '0;
   logic [15:0] req_box_right = '0;
   logic [15:0] req_box_bottom = '0;
   logic [15:0] req_box_score = '0;
   logic [7:0]  req_class_id = '0;
   logic [15:0] req_anchor_index = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_outcome;
   logic [7:0]  rsp_slot;
   logic [15:0] rsp_anchor_echo;
   logic [8:0]  rsp_kept_total;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_score_threshold = '0;

   suppression_tracker tracker;
   logic [15:0]        live_threshold = RESET_THRESHOLD;
   logic [15:0]        phase_threshold [PHASES];
   bit                 calm = 1'b0;
   int                 items_sent = 0;
   int                 cycles = 0;

   greedy_class_box_suppression_unit dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_new_frame       (req_new_frame),
      .req_box_left        (req_box_left),
      .req_box_top         (req_box_top),
      .req_box_right       (req_box_right),
      .req_box_bottom      (req_box_bottom),
      .req_box_score       (req_box_score),
      .req_class_id        (req_class_id),
      .req_anchor_index    (req_anchor_index),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_outcome         (rsp_outcome),
      .rsp_slot            (rsp_slot),
      .rsp_anchor_echo     (rsp_anchor_echo),
      .rsp_kept_total      (rsp_kept_total),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_score_threshold (csr_score_threshold)
   );

   // clock
   initial begin
      forever #1 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("greedy_class_box_suppression_unit regression: fail");
         $finish;
      end
   end

   // transaction monitor: every handshake seen at the edge it completes
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            tracker.threshold = csr_score_threshold;
         if (req_valid && req_ready)
            tracker.note_candidate('{req_new_frame, req_box_left, req_box_top,
                                     req_box_right, req_box_bottom, req_box_score,
                                     req_class_id, req_anchor_index});
         if (rsp_valid && rsp_ready)
            tracker.check_verdict('{gcbs_pkg::outcome_type'(rsp_outcome), rsp_slot,
                                    rsp_anchor_echo, rsp_kept_total});
      end
   end

   // result-side backpressure in random bursts
   initial begin
      int burst;

      @(posedge clock);
      forever begin
         if (calm) begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end else begin
            burst = $urandom_range(1, 12);
            rsp_ready <= ($urandom_range(0, 2) != 0);
            repeat (burst) @(posedge clock);
         end
      end
   end

   task automatic pause_sender(int count);
      req_valid <= 1'b0;
      repeat (count) @(posedge clock);
   endtask

   task automatic send_candidate(candidate_type c);
      if (!calm && $urandom_range(0, 3) == 0)
         pause_sender($urandom_range(1, 12));
      req_valid        <= 1'b1;
      req_new_frame    <= c.new_frame;
      req_box_left     <= c.left;
      req_box_top      <= c.top;
      req_box_right    <= c.right;
      req_box_bottom   <= c.bottom;
      req_box_score    <= c.score;
      req_class_id     <= c.class_id;
      req_anchor_index <= c.anchor;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   // hold off the sender until every verdict is back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending_verdicts.size() != 0) @(posedge clock);
   endtask

   task automatic write_threshold(logic [15:0] value);
      wait_drained();
      repeat (8) @(posedge clock);
      live_threshold      = value;
      csr_valid           <= 1'b1;
      csr_score_threshold <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic candidate_type box_of(logic nf, logic [15:0] l, logic [15:0] t,
                                            logic [15:0] r, logic [15:0] b,
                                            logic [15:0] score, logic [7:0] cls,
                                            logic [15:0] anchor);
      return '{nf, l, t, r, b, score, cls, anchor};
   endfunction

   // score spread: anywhere, near the threshold, or above it
   function automatic logic [15:0] pick_score();
      int s;

      case ($urandom_range(0, 2))
         0:       s = $urandom_range(0, 65535);
         1:       s = int'(live_threshold) + $urandom_range(0, 64) - 32;
         default: s = $urandom_range(live_threshold, 65535);
      endcase
      if (s < 0)
         s = 0;
      if (s > 65535)
         s = 65535;
      return 16'(s);
   endfunction

   function automatic logic [15:0] jitter(int base, int spread);
      int v;

      v = base + $urandom_range(0, 2 * spread) - spread;
      if (v < 0)
         v = 0;
      if (v > 65535)
         v = 65535;
      return 16'(v);
   endfunction

   // one frame of candidates clustered around a few objects
   task automatic run_frame(int length);
      int            obj_left [8];
      int            obj_top [8];
      int            obj_w [8];
      int            obj_h [8];
      int            obj_class [8];
      int            objects;
      int            o;
      candidate_type c;

      objects = $urandom_range(1, 8);
      for (int k = 0; k < objects; k++) begin
         obj_w[k]     = $urandom_range(16, 3000);
         obj_h[k]     = $urandom_range(16, 3000);
         obj_left[k]  = $urandom_range(0, 65535 - obj_w[k]);
         obj_top[k]   = $urandom_range(0, 65535 - obj_h[k]);
         obj_class[k] = $urandom_range(0, 3);
      end
      for (int n = 0; n < length; n++) begin
         o            = $urandom_range(0, objects - 1);
         c.new_frame  = (n == 0) || ($urandom_range(0, 63) == 0);
         c.score      = pick_score();
         c.class_id   = 8'(obj_class[o]);
         c.anchor     = 16'($urandom);
         case ($urandom_range(0, 15))
            0: begin
               // noise over the full field ranges
               c.left     = 16'($urandom);
               c.top      = 16'($urandom);
               c.right    = 16'($urandom);
               c.bottom   = 16'($urandom);
               c.score    = 16'($urandom);
               c.class_id = 8'($urandom);
            end
            1: begin
               // zero-width box
               c.left   = jitter(obj_left[o], 40);
               c.right  = 16'(c.left - $urandom_range(0, (c.left > 40) ? 40 : c.left));
               c.top    = 16'(obj_top[o]);
               c.bottom = 16'(obj_top[o] + obj_h[o]);
            end
            default: begin
               c.left   = jitter(obj_left[o], obj_w[o] / 4);
               c.right  = jitter(obj_left[o] + obj_w[o], obj_w[o] / 4);
               c.top    = jitter(obj_top[o], obj_h[o] / 4);
               c.bottom = jitter(obj_top[o] + obj_h[o], obj_h[o] / 4);
            end
         endcase
         if ($urandom_range(0, 7) == 0)
            c.class_id = 8'($urandom);
         send_candidate(c);
      end
   endtask

   // Fill the table with disjoint grid boxes, then hit it while full: copies
   // of kept grid slots replace or get suppressed when their class matches,
   // else they find no room, like the boxes in the gaps.
   task automatic run_fill_frame();
      candidate_type c;
      int            grid_slot;

      for (int n = 0; n < TABLE_DEPTH + 24; n++) begin
         grid_slot   = (n < TABLE_DEPTH) ? n : $urandom_range(0, TABLE_DEPTH - 1);
         c.new_frame = (n == 0);
         c.score     = 16'($urandom_range(live_threshold, 65535));
         c.class_id  = 8'($urandom_range(0, 3));
         c.anchor    = 16'($urandom);
         c.left      = 16'((grid_slot % 16) * GRID_PITCH + $urandom_range(0, 200));
         c.top       = 16'((grid_slot / 16) * GRID_PITCH + $urandom_range(0, 200));
         c.right     = c.left + 16'($urandom_range(2500, 2800));
         c.bottom    = c.top + 16'($urandom_range(2500, 2800));
         if (n >= TABLE_DEPTH && n % 2 == 1) begin
            c.left  = 16'((grid_slot % 16) * GRID_PITCH + 3300);
            c.right = c.left + 16'd500;
         end
         send_candidate(c);
      end
   endtask

   // main sequence
   initial begin
      int goal;
      bit paused;

      tracker = new();
      paused  = 1'b0;
      phase_threshold = '{16'd0, 16'hFFFF, RESET_THRESHOLD, 16'($urandom),
                          16'd32768, 16'd1, 16'($urandom)};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed cases under the reset threshold
      send_candidate(box_of(1, 16, 16, 32, 32, 16'hFFFF, 0, 0));
      send_candidate(box_of(0, 16, 16, 32, 32, 0, 0, 1));
      send_candidate(box_of(0, 16, 16, 32, 32, RESET_THRESHOLD - 16'd1, 0, 2));
      send_candidate(box_of(0, 16, 16, 32, 32, RESET_THRESHOLD, 0, 3));
      // equal score on overlap is suppressed
      send_candidate(box_of(0, 16, 16, 32, 32, 16'hFFFF, 0, 4));
      // same box, other class
      send_candidate(box_of(0, 16, 16, 32, 32, 16'hFFFF, 7, 5));
      // degenerate boxes never overlap
      send_candidate(box_of(0, 100, 100, 100, 200, 50000, 0, 6));
      send_candidate(box_of(0, 100, 100, 100, 200, 60000, 0, 7));
      send_candidate(box_of(0, 500, 500, 600, 400, 60000, 0, 8));
      // IoU exactly one half does not count, just above it replaces
      send_candidate(box_of(0, 300, 0, 324, 16, 50000, 2, 9));
      send_candidate(box_of(0, 308, 0, 332, 16, 50000, 2, 10));
      send_candidate(box_of(0, 307, 0, 331, 16, 60000, 2, 11));
      // full-range boxes, then a zero-size box at the far corner
      send_candidate(box_of(0, 0, 0, 16'hFFFF, 16'hFFFF, 50000, 8'hFF, 16'hFFFF));
      send_candidate(box_of(0, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 16'h8000));
      send_candidate(box_of(0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF,
                            16'h7FFF));
      // new frame that drops its own box, then a kept box, then a new frame that keeps its own
      send_candidate(box_of(1, 16, 16, 32, 32, 100, 0, 16'h5555));
      send_candidate(box_of(0, 16, 16, 32, 32, 46000, 3, 16'hAAAA));
      send_candidate(box_of(1, 40, 40, 80, 80, 16'hFFFF, 0, 16'h1234));

      // random phases, one threshold each
      for (int p = 0; p < PHASES; p++) begin
         write_threshold(phase_threshold[p]);
         calm = (p == PHASES - 1);
         goal = items_sent + RANDOM_ITEMS / PHASES;
         if (p == 0 || p == 4)
            run_fill_frame();
         while (items_sent < goal) begin
            run_frame(($urandom_range(0, 7) == 0) ? $urandom_range(25, 80)
                                                  : $urandom_range(1, 24));
            if (p == 1 && !paused) begin
               wait_drained();
               paused = 1'b1;
            end
         end
      end

      // drain and let the unit settle
      wait_drained();
      repeat (20) @(posedge clock);
      if (tracker.pending_verdicts.size() != 0)
         tracker.report("verdicts never returned", tracker.pending_verdicts.size(), 0);
      if (tracker.errors == 0)
         $display("greedy_class_box_suppression_unit regression: pass");
      else
         $display("greedy_class_box_suppression_unit regression: fail");
      $finish;
   end

endmodule
